/* src/pacc_pkg.sv */
// Shared constants, types and register codes of the platoon acceleration controller.
package pacc_pkg;

    // Value format: signed Q8.8 speeds, accelerations and gains; unsigned Q8.8 distances
    localparam int VALUE_WIDTH = 16;
    localparam int FRAC_BITS   = 8;
    localparam int CFG_INDEX_W = 4;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic        [VALUE_WIDTH-1:0] uvalue_t;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TARGET_SPEED        = CFG_INDEX_W'(0),
        REG_TARGET_SPACING      = CFG_INDEX_W'(1),
        REG_MIN_ACCEL           = CFG_INDEX_W'(2),
        REG_MAX_ACCEL           = CFG_INDEX_W'(3),
        REG_GAIN_PREC_ACC       = CFG_INDEX_W'(4),
        REG_GAIN_LEAD_ACC       = CFG_INDEX_W'(5),
        REG_GAIN_REL_PREC_SPEED = CFG_INDEX_W'(6),
        REG_GAIN_REL_LEAD_SPEED = CFG_INDEX_W'(7)
    } cfg_index_t;

    typedef struct packed {
        value_t  target_speed;
        uvalue_t target_spacing;
        value_t  min_accel;
        value_t  max_accel;
        value_t  gain_prec_acc;
        value_t  gain_lead_acc;
        value_t  gain_rel_prec_speed;
        value_t  gain_rel_lead_speed;
    } cfg_t;

    // Speed and command of the last leader and of the last vehicle of any kind
    typedef struct packed {
        value_t leader_speed;
        value_t leader_accel;
        value_t prev_speed;
        value_t prev_accel;
    } hist_t;

endpackage

/* src/pacc_regs.sv */
// Configuration register file of the platoon acceleration controller.
module pacc_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [pacc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pacc_pkg::VALUE_WIDTH-1:0]    cfg_data,
    output pacc_pkg::cfg_t                      cfg
);
    import pacc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; indexes past the list leave everything unchanged
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                REG_TARGET_SPEED:        cfg_next.target_speed        = cfg_data;
                REG_TARGET_SPACING:      cfg_next.target_spacing      = cfg_data;
                REG_MIN_ACCEL:           cfg_next.min_accel           = cfg_data;
                REG_MAX_ACCEL:           cfg_next.max_accel           = cfg_data;
                REG_GAIN_PREC_ACC:       cfg_next.gain_prec_acc       = cfg_data;
                REG_GAIN_LEAD_ACC:       cfg_next.gain_lead_acc       = cfg_data;
                REG_GAIN_REL_PREC_SPEED: cfg_next.gain_rel_prec_speed = cfg_data;
                REG_GAIN_REL_LEAD_SPEED: cfg_next.gain_rel_lead_speed = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_speed        <= value_t'(0);
            cfg_reg.target_spacing      <= uvalue_t'(2560);
            cfg_reg.min_accel           <= value_t'(-2048);
            cfg_reg.max_accel           <= value_t'(768);
            cfg_reg.gain_prec_acc       <= value_t'(128);
            cfg_reg.gain_lead_acc       <= value_t'(128);
            cfg_reg.gain_rel_prec_speed <= value_t'(-384);
            cfg_reg.gain_rel_lead_speed <= value_t'(-128);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/pacc_law.sv */
// Control law of the platoon acceleration controller: leader and follower command, clamp, done.
module pacc_law (
    input  pacc_pkg::cfg_t                   cfg,
    input  pacc_pkg::hist_t                  hist,
    input  logic                             is_leader,
    input  logic                             is_joining,
    input  logic [pacc_pkg::VALUE_WIDTH-1:0] vehicle_speed,
    input  logic [pacc_pkg::VALUE_WIDTH-1:0] gap_distance,
    output logic [pacc_pkg::VALUE_WIDTH-1:0] accel_command,
    output logic                             manoeuvre_done
);
    import pacc_pkg::*;

    localparam int VW    = VALUE_WIDTH;
    localparam int SW    = VW + 1;
    localparam int XW    = VW + 3;
    localparam int SUM_W = 2 * VW + 4;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (FRAC_BITS - 1));
    localparam logic        [SW-1:0]    ONE_METER  = SW'(1 << FRAC_BITS);

    // Divide by ten: bias the dividend positive by a multiple of ten, then multiply by
    // ceil(2^DIV_SHIFT / 10); exact for every biased dividend below 2^XW
    localparam int     DIV_MUL_W = VW + 4;
    localparam int     DIV_SHIFT = VW + 7;
    localparam longint DIV_OFS_Q = longint'(1) << (VW - 2);
    localparam longint DIV_OFS   = 10 * DIV_OFS_Q;
    localparam longint DIV_MUL   = ((longint'(1) << DIV_SHIFT) + 9) / 10;

    // Leader path
    logic signed [SW-1:0]        lead_err;
    logic signed [XW-1:0]        lead_x;
    logic        [XW-1:0]        lead_y;
    logic        [XW+DIV_MUL_W-1:0] lead_prod;
    logic        [VW-1:0]        lead_q;
    logic signed [VW+1:0]        lead_val;

    // Follower path
    logic signed [SW-1:0]        rel_prec;
    logic signed [SW-1:0]        rel_lead;
    logic signed [SW-1:0]        space_err;
    logic signed [2*VW-1:0]      term_prec_acc;
    logic signed [2*VW-1:0]      term_lead_acc;
    logic signed [2*VW:0]        term_rel_prec;
    logic signed [2*VW:0]        term_rel_lead;
    logic signed [SUM_W-1:0]     sum;
    logic signed [SUM_W-1:0]     follow_val;

    logic signed [SUM_W-1:0]     raw;
    logic signed [SUM_W-1:0]     lim_lo;
    logic signed [SUM_W-1:0]     lim_hi;

    // Leader: round((target - speed) / 5) = floor((2d + 5) / 10), by reciprocal multiply
    always_comb begin
        lead_err  = $signed({cfg.target_speed[VW-1], cfg.target_speed})
                  - $signed({vehicle_speed[VW-1], vehicle_speed});
        lead_x    = (XW'(lead_err) <<< 1) + XW'(5);
        lead_y    = XW'(lead_x) + XW'(DIV_OFS);
        lead_prod = (XW + DIV_MUL_W)'(lead_y) * (XW + DIV_MUL_W)'(DIV_MUL);
        lead_q    = lead_prod[DIV_SHIFT +: VW];
        lead_val  = $signed({2'b00, lead_q}) - (VW + 2)'(DIV_OFS_Q);
    end

    // Follower: four gain products plus the spacing error, rounded to Q8.8
    always_comb begin
        rel_prec  = $signed({vehicle_speed[VW-1], vehicle_speed})
                  - $signed({hist.prev_speed[VW-1], hist.prev_speed});
        rel_lead  = $signed({vehicle_speed[VW-1], vehicle_speed})
                  - $signed({hist.leader_speed[VW-1], hist.leader_speed});
        space_err = $signed({1'b0, gap_distance}) - $signed({1'b0, cfg.target_spacing});
        term_prec_acc = (2 * VW)'(cfg.gain_prec_acc) * (2 * VW)'(hist.prev_accel);
        term_lead_acc = (2 * VW)'(cfg.gain_lead_acc) * (2 * VW)'(hist.leader_accel);
        term_rel_prec = (2 * VW + 1)'($signed({cfg.gain_rel_prec_speed[VW-1],
                                               cfg.gain_rel_prec_speed}))
                      * (2 * VW + 1)'(rel_prec);
        term_rel_lead = (2 * VW + 1)'($signed({cfg.gain_rel_lead_speed[VW-1],
                                               cfg.gain_rel_lead_speed}))
                      * (2 * VW + 1)'(rel_lead);
        sum = SUM_W'(term_prec_acc) + SUM_W'(term_lead_acc)
            + SUM_W'(term_rel_prec) + SUM_W'(term_rel_lead)
            + (SUM_W'(space_err) <<< FRAC_BITS);
        follow_val = (sum + ROUND_HALF) >>> FRAC_BITS;
    end

    // Clamp; the lower limit is checked first so it wins on inverted limits
    always_comb begin
        raw    = is_leader ? SUM_W'(lead_val) : follow_val;
        lim_lo = SUM_W'($signed(cfg.min_accel));
        lim_hi = SUM_W'($signed(cfg.max_accel));
        priority if (raw < lim_lo) begin
            accel_command = cfg.min_accel;
        end else if (raw > lim_hi) begin
            accel_command = cfg.max_accel;
        end else begin
            accel_command = raw[VW-1:0];
        end
    end

    // Join finished: leader, or gap within target spacing plus one meter
    assign manoeuvre_done = is_joining
                          && (is_leader
                              || ({1'b0, gap_distance} <= ({1'b0, cfg.target_spacing} + ONE_METER)));

endmodule

/* src/platoon_acceleration_controller_top.sv */
// Top level of the platoon acceleration controller: input stage, history registers, result stage.
//
// Takes one vehicle record per request, leader first, and returns one request with the clamped
// Q8.8 acceleration command and the join-done flag. A record is accepted in every cycle unless
// both stages hold a record and m_ready is low; its result moves from the input register to the
// result register and waits there on m_ready. The only feedback is the history of the last
// leader and last vehicle, updated in the cycle a command moves into the result register, so
// consecutive records chain without bubbles. While a result waits on m_ready the input register
// still takes one more record. Configuration writes are taken in any cycle and apply to records
// that arrive afterwards; write only while idle.
module platoon_acceleration_controller_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_is_leader,
    input  logic                                s_is_joining,
    input  logic [pacc_pkg::VALUE_WIDTH-1:0]    s_vehicle_speed,
    input  logic [pacc_pkg::VALUE_WIDTH-1:0]    s_gap_distance,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pacc_pkg::VALUE_WIDTH-1:0]    m_accel_command,
    output logic                                m_manoeuvre_done,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pacc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pacc_pkg::VALUE_WIDTH-1:0]    cfg_data
);
    import pacc_pkg::*;

    cfg_t    cfg;

    logic    in_valid_reg;
    logic    in_leader_reg;
    logic    in_joining_reg;
    value_t  in_speed_reg;
    uvalue_t in_gap_reg;

    hist_t   hist_reg;
    hist_t   hist_next;

    logic    out_valid_reg;
    value_t  out_cmd_reg;
    logic    out_done_reg;
    value_t  cmd_next;
    logic    done_next;

    logic    advance;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    pacc_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake between input register and result register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_leader_reg  <= s_is_leader;
            in_joining_reg <= s_is_joining;
            in_speed_reg   <= s_vehicle_speed;
            in_gap_reg     <= s_gap_distance;
        end
    end

    // Command and done flag
    pacc_law u_law (
        .cfg            (cfg),
        .hist           (hist_reg),
        .is_leader      (in_leader_reg),
        .is_joining     (in_joining_reg),
        .vehicle_speed  (in_speed_reg),
        .gap_distance   (in_gap_reg),
        .accel_command  (cmd_next),
        .manoeuvre_done (done_next)
    );

    // History: a leader record refreshes both leader and preceding values
    always_comb begin
        hist_next            = hist_reg;
        hist_next.prev_speed = in_speed_reg;
        hist_next.prev_accel = cmd_next;
        if (in_leader_reg) begin
            hist_next.leader_speed = in_speed_reg;
            hist_next.leader_accel = cmd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
        end else if (advance) begin
            hist_reg <= hist_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_cmd_reg  <= cmd_next;
            out_done_reg <= done_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_accel_command  = out_cmd_reg;
    assign m_manoeuvre_done = out_done_reg;

    // Leader record leaves leader and preceding history equal
    a_leader_hist: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_leader_reg |=> hist_reg.leader_accel == hist_reg.prev_accel
                                  && hist_reg.leader_speed == hist_reg.prev_speed)
        else $error("leader history not mirrored");

    // Non-joining record never reports done
    a_done_join: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_joining_reg |=> !out_done_reg)
        else $error("done flag on non-joining record");

    // With ordered limits a delivered command lies within them
    a_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && ($signed(cfg.min_accel) <= $signed(cfg.max_accel))
        |-> ($signed(out_cmd_reg) >= $signed(cfg.min_accel))
         && ($signed(out_cmd_reg) <= $signed(cfg.max_accel)))
        else $error("command outside limits");

    // Input stalls only when both stages hold a record
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled with room downstream");

endmodule

/* tb/platoon_acceleration_controller_top_tb.sv */
// Self-checking testbench of the platoon acceleration controller: command predictor and driver.
import pacc_pkg::*;

// One predicted command request
typedef struct packed {
    value_t accel;
    logic   done;
} vehicle_cmd_t;

// Tracks register settings and platoon history, predicts commands and checks them in order
class accel_scoreboard;
    cfg_t         regs;
    longint       lead_speed;
    longint       lead_accel;
    longint       prec_speed;
    longint       prec_accel;
    vehicle_cmd_t cmd_q[$];
    int           errors;

    function new();
        regs.target_speed        = 16'sd0;
        regs.target_spacing      = 16'd2560;
        regs.min_accel           = -16'sd2048;
        regs.max_accel           = 16'sd768;
        regs.gain_prec_acc       = 16'sd128;
        regs.gain_lead_acc       = 16'sd128;
        regs.gain_rel_prec_speed = -16'sd384;
        regs.gain_rel_lead_speed = -16'sd128;
        lead_speed = 0;
        lead_accel = 0;
        prec_speed = 0;
        prec_accel = 0;
        errors     = 0;
    endfunction

    // Indexes past the register list are dropped by the block
    function void write_reg(logic [CFG_INDEX_W-1:0] idx, uvalue_t data);
        case (idx)
            REG_TARGET_SPEED:        regs.target_speed        = data;
            REG_TARGET_SPACING:      regs.target_spacing      = data;
            REG_MIN_ACCEL:           regs.min_accel           = data;
            REG_MAX_ACCEL:           regs.max_accel           = data;
            REG_GAIN_PREC_ACC:       regs.gain_prec_acc       = data;
            REG_GAIN_LEAD_ACC:       regs.gain_lead_acc       = data;
            REG_GAIN_REL_PREC_SPEED: regs.gain_rel_prec_speed = data;
            REG_GAIN_REL_LEAD_SPEED: regs.gain_rel_lead_speed = data;
            default: ;
        endcase
    endfunction

    static function longint floor_div10(longint x);
        longint q;
        q = x / 10;
        if (x < 0 && (x % 10) != 0)
            q = q - 1;
        return q;
    endfunction

    // Lower limit is tested first, so it wins when the limits are inverted
    function longint clamp_accel(longint a);
        if (a < longint'($signed(regs.min_accel)))
            return longint'($signed(regs.min_accel));
        if (a > longint'($signed(regs.max_accel)))
            return longint'($signed(regs.max_accel));
        return a;
    endfunction

    function void note_record(logic leader, logic joining, value_t speed, uvalue_t gap);
        longint       spd;
        longint       spacing;
        longint       sum;
        longint       raw;
        longint       cmd;
        vehicle_cmd_t want;
        spd     = longint'($signed(speed));
        spacing = longint'($unsigned(regs.target_spacing));
        if (leader) begin
            // speed error / 5, rounded to nearest
            raw = floor_div10(2 * (longint'($signed(regs.target_speed)) - spd) + 5);
        end else begin
            // exact Q16.16 sum, halves round up
            sum = longint'($signed(regs.gain_prec_acc)) * prec_accel
                + longint'($signed(regs.gain_lead_acc)) * lead_accel
                + longint'($signed(regs.gain_rel_prec_speed)) * (spd - prec_speed)
                + longint'($signed(regs.gain_rel_lead_speed)) * (spd - lead_speed)
                + (longint'($unsigned(gap)) - spacing) * 256;
            raw = (sum + 128) >>> 8;
        end
        cmd = clamp_accel(raw);
        want.accel = value_t'(cmd);
        want.done  = joining && (leader || longint'($unsigned(gap)) <= spacing + 256);
        if (leader) begin
            lead_speed = spd;
            lead_accel = cmd;
        end
        prec_speed = spd;
        prec_accel = cmd;
        cmd_q.push_back(want);
    endfunction

    function void check_command(value_t accel, logic done);
        vehicle_cmd_t want;
        if (cmd_q.size() == 0) begin
            $display("%0t: unexpected command request accel=%0d done=%0b", $time, accel, done);
            errors++;
            return;
        end
        want = cmd_q.pop_front();
        if (accel !== want.accel) begin
            $display("%0t: accel_command expected %0d actual %0d", $time, want.accel, accel);
            errors++;
        end
        if (done !== want.done) begin
            $display("%0t: manoeuvre_done expected %0b actual %0b", $time, want.done, done);
            errors++;
        end
    endfunction

    function int pending();
        return cmd_q.size();
    endfunction

    function void close_out();
        if (cmd_q.size() != 0) begin
            $display("%0t: %0d command requests never arrived", $time, cmd_q.size());
            errors++;
        end
    endfunction
endclass

module platoon_acceleration_controller_top_tb;

    localparam int NUM_CFG_REGS    = 8;
    localparam int DRAIN_CYCLES    = 4;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int NUM_PHASES      = 7;

    typedef enum int {
        SET_DEFAULT,
        SET_TYPICAL,
        SET_WIDE,
        SET_INVERTED,
        SET_EXTREME_HIGH,
        SET_EXTREME_LOW
    } setting_kind_t;

    logic                   aclk             = 1'b0;
    logic                   aresetn          = 1'b0;
    logic                   s_valid          = 1'b0;
    logic                   s_ready;
    logic                   s_is_leader      = 1'b0;
    logic                   s_is_joining     = 1'b0;
    logic [VALUE_WIDTH-1:0] s_vehicle_speed  = '0;
    logic [VALUE_WIDTH-1:0] s_gap_distance   = '0;
    logic                   m_valid;
    logic                   m_ready          = 1'b0;
    logic [VALUE_WIDTH-1:0] m_accel_command;
    logic                   m_manoeuvre_done;
    logic                   cfg_valid        = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index        = '0;
    logic [VALUE_WIDTH-1:0] cfg_data         = '0;

    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              stall_cycles  = 0;
    accel_scoreboard sb;

    platoon_acceleration_controller_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_is_leader      (s_is_leader),
        .s_is_joining     (s_is_joining),
        .s_vehicle_speed  (s_vehicle_speed),
        .s_gap_distance   (s_gap_distance),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_accel_command  (m_accel_command),
        .m_manoeuvre_done (m_manoeuvre_done),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Result check and stall watchdog
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_command(m_accel_command, m_manoeuvre_done);
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAIL platoon_acceleration_controller_top");
                $finish;
            end
        end
    end

    // One vehicle record; starts and ends at a falling edge
    task automatic send_record(input logic leader, input logic joining,
                               input value_t speed, input uvalue_t gap);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_is_leader     = leader;
        s_is_joining    = joining;
        s_vehicle_speed = speed;
        s_gap_distance  = gap;
        do @(posedge aclk); while (!s_ready);
        sb.note_record(leader, joining, speed, gap);
        @(negedge aclk);
    endtask

    // Leaves cfg_valid high so back-to-back writes do not toggle it
    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input uvalue_t data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic load_settings(input cfg_t c);
        wait_idle();
        write_cfg(REG_TARGET_SPEED,        c.target_speed);
        write_cfg(REG_TARGET_SPACING,      c.target_spacing);
        write_cfg(REG_MIN_ACCEL,           c.min_accel);
        write_cfg(REG_MAX_ACCEL,           c.max_accel);
        write_cfg(REG_GAIN_PREC_ACC,       c.gain_prec_acc);
        write_cfg(REG_GAIN_LEAD_ACC,       c.gain_lead_acc);
        write_cfg(REG_GAIN_REL_PREC_SPEED, c.gain_rel_prec_speed);
        write_cfg(REG_GAIN_REL_LEAD_SPEED, c.gain_rel_lead_speed);
        cfg_valid = 1'b0;
    endtask

    function automatic value_t small_signed(int span);
        return value_t'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic cfg_t make_settings(setting_kind_t kind);
        cfg_t c;
        c = cfg_t'({$urandom, $urandom, $urandom, $urandom});
        case (kind)
            SET_DEFAULT: begin
                c.target_speed        = 16'sd0;
                c.target_spacing      = 16'd2560;
                c.min_accel           = -16'sd2048;
                c.max_accel           = 16'sd768;
                c.gain_prec_acc       = 16'sd128;
                c.gain_lead_acc       = 16'sd128;
                c.gain_rel_prec_speed = -16'sd384;
                c.gain_rel_lead_speed = -16'sd128;
            end
            SET_TYPICAL: begin
                c.target_speed        = value_t'($urandom_range(40 * 256));
                c.target_spacing      = uvalue_t'($urandom_range(256, 30 * 256));
                c.min_accel           = value_t'(-int'($urandom_range(256, 4096)));
                c.max_accel           = value_t'($urandom_range(2048));
                c.gain_prec_acc       = small_signed(512);
                c.gain_lead_acc       = small_signed(512);
                c.gain_rel_prec_speed = small_signed(1024);
                c.gain_rel_lead_speed = small_signed(1024);
            end
            SET_WIDE: begin
                c.min_accel = -16'sd32768;
                c.max_accel = 16'sd32767;
            end
            SET_INVERTED: begin
                c.min_accel = value_t'($urandom_range(32767));
                c.max_accel = value_t'(-int'($urandom_range(1, 32768)));
            end
            SET_EXTREME_HIGH: begin
                c.target_speed        = 16'sd32767;
                c.target_spacing      = 16'hffff;
                c.min_accel           = 16'sd32767;
                c.max_accel           = 16'sd32767;
                c.gain_prec_acc       = 16'sd32767;
                c.gain_lead_acc       = 16'sd32767;
                c.gain_rel_prec_speed = 16'sd32767;
                c.gain_rel_lead_speed = 16'sd32767;
            end
            SET_EXTREME_LOW: begin
                c.target_speed        = -16'sd32768;
                c.target_spacing      = 16'h0000;
                c.min_accel           = -16'sd32768;
                c.max_accel           = 16'sd32767;
                c.gain_prec_acc       = -16'sd32768;
                c.gain_lead_acc       = -16'sd32768;
                c.gain_rel_prec_speed = -16'sd32768;
                c.gain_rel_lead_speed = -16'sd32768;
            end
            default: ;
        endcase
        return c;
    endfunction

    // Mostly near a center value, now and then anywhere in range
    function automatic value_t near_value(value_t center, int spread);
        if ($urandom_range(9) == 0)
            return value_t'($urandom);
        return value_t'(int'(center) + small_signed(spread));
    endfunction

    // Platoons of a leader and a few followers, mixed with stray records
    task automatic send_traffic(input int count);
        int     sent;
        int     followers;
        int     join_pos;
        value_t lead_v;
        value_t v;
        uvalue_t gap;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 80) begin
                lead_v    = near_value(sb.regs.target_speed, 2048);
                followers = $urandom_range(1, 6);
                join_pos  = ($urandom_range(99) < 40) ? $urandom_range(1, followers) : 0;
                send_record(1'b1, $urandom_range(19) == 0, lead_v, uvalue_t'($urandom));
                sent++;
                for (int i = 1; i <= followers; i++) begin
                    v   = near_value(lead_v, 512);
                    gap = uvalue_t'(near_value(value_t'(sb.regs.target_spacing), 768));
                    send_record(1'b0, i == join_pos, v, gap);
                    sent++;
                end
            end else begin
                send_record(1'($urandom_range(1)), 1'($urandom_range(1)), value_t'($urandom),
                            uvalue_t'($urandom));
                sent++;
            end
        end
    endtask

    task automatic set_idle_mode(input int phase);
        if (phase < 3) begin
            send_idle_pct = 37;
            recv_idle_pct = 54;
        end else if (phase < 6) begin
            send_idle_pct = 54;
            recv_idle_pct = 37;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    initial begin
        setting_kind_t plan [NUM_PHASES];
        plan = '{SET_TYPICAL, SET_WIDE, SET_INVERTED, SET_EXTREME_HIGH, SET_EXTREME_LOW,
                 SET_TYPICAL, SET_DEFAULT};
        sb = new();
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;
        set_idle_mode(0);

        // Directed records on reset settings (spacing 10 m, limits -8..3)
        send_record(1'b0, 1'b0, 16'sd0, 16'd0);          // follower ahead of any leader
        send_record(1'b0, 1'b1, 16'sd256, 16'd2816);     // join gap exactly spacing + 1 m
        send_record(1'b0, 1'b1, 16'sd256, 16'd2817);     // one LSB beyond
        send_record(1'b0, 1'b1, 16'sd0, 16'd0);
        send_record(1'b0, 1'b0, 16'sd0, 16'd2560);
        send_record(1'b1, 1'b1, -16'sd32768, 16'hffff);  // joining leader, clamps high
        send_record(1'b0, 1'b0, 16'sd32767, 16'hffff);
        send_record(1'b0, 1'b0, -16'sd32768, 16'd0);
        send_record(1'b1, 1'b0, 16'sd32767, 16'd0);      // clamps low
        send_record(1'b0, 1'b1, 16'sd32767, 16'd0);
        send_record(1'b1, 1'b0, 16'sd0, 16'd0);
        send_record(1'b1, 1'b0, -16'sd2, 16'd0);         // rounding around zero
        send_record(1'b1, 1'b0, -16'sd3, 16'd0);
        send_record(1'b1, 1'b0, 16'sd3, 16'd0);
        send_record(1'b1, 1'b0, 16'sd2, 16'd0);
        send_record(1'b0, 1'b0, 16'sd10, 16'd2600);
        send_record(1'b0, 1'b1, -16'sd10, 16'd2400);
        send_record(1'b1, 1'b1, 16'sd512, 16'd0);
        send_record(1'b0, 1'b0, 16'sd600, 16'd3000);
        send_record(1'b0, 1'b0, 16'sd400, 16'd2000);

        // Writes past the register list must leave the settings alone
        wait_idle();
        for (int i = NUM_CFG_REGS; i < (1 << CFG_INDEX_W); i++)
            write_cfg(CFG_INDEX_W'(i), uvalue_t'($urandom));
        cfg_valid = 1'b0;
        send_traffic(20);

        for (int p = 0; p < NUM_PHASES; p++) begin
            load_settings(make_settings(plan[p]));
            set_idle_mode(p + 1);
            send_traffic(ITEMS_PER_PHASE);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.close_out();
        if (sb.errors == 0)
            $display("PASS platoon_acceleration_controller_top");
        else
            $display("FAIL platoon_acceleration_controller_top");
        $finish;
    end

endmodule

/* platoon_acceleration_controller_top.f */
src/pacc_pkg.sv
src/pacc_regs.sv
src/pacc_law.sv
src/platoon_acceleration_controller_top.sv
tb/platoon_acceleration_controller_top_tb.sv
